/* rtl/rdq_pkg.sv */
// Shared types and constants for the reversible deque.
package rdq_pkg;

	localparam int DEPTH_DEF = 64;
	localparam int KIND_W    = 3;
	localparam int DATA_W    = 32;
	localparam int STATUS_W  = 2;

	typedef enum logic [KIND_W-1:0] {
		KIND_PUSH_TAIL = 3'd0,
		KIND_PUSH_HEAD = 3'd1,
		KIND_POP_HEAD  = 3'd2,
		KIND_POP_TAIL  = 3'd3,
		KIND_REVERSE   = 3'd4
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK    = 2'd0,
		STATUS_EMPTY = 2'd1,
		STATUS_FULL  = 2'd2
	} status_t;

	localparam logic signed [DATA_W-1:0] POP_EMPTY_VALUE = -32'sd1;

endpackage

/* rtl/rdq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module rdq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* rtl/reversible_deque_top.sv */
// Top level of the bounded double-ended queue with constant-time reverse.
//
// Channel  Direction  Handshake          Payload
// command  in         start, busy        kind, value
// result   out        done (one cycle)   popped, status, count
//
// One transaction is accepted per cycle; busy stays low.
// Each command passes through the input register, then the pointer update and
// the store read, whose registered data is the result stage.
// Reset clears pointers, count and orientation; the store itself is not cleared.
// The receiver cannot stall: each result is shown for exactly one cycle.
module reversible_deque_top
	import rdq_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [KIND_W-1:0]               kind,
	input  logic signed [DATA_W-1:0]        value,
	output logic                            done,
	output logic signed [DATA_W-1:0]        popped,
	output logic [STATUS_W-1:0]             status,
	output logic [$clog2(DEPTH+1)-1:0]      count
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);
	localparam logic [AW-1:0] LAST_IDX  = AW'(DEPTH - 1);
	localparam logic [AW:0]   WRAP_SPAN = (AW+1)'(DEPTH);

	logic                     valid_s1;
	logic [KIND_W-1:0]        kind_s1;
	logic [DATA_W-1:0]        value_s1;

	logic                     valid_s2;
	logic [STATUS_W-1:0]      status_s2;
	logic [CW-1:0]            count_s2;
	logic                     pop_ok_s2;

	logic [AW-1:0]            front_q;
	logic [CW-1:0]            occ_q;
	logic                     rev_q;

	logic [AW-1:0]            front_d;
	logic [CW-1:0]            occ_d;
	logic                     rev_d;
	status_t                  status_d;
	logic                     pop_ok_d;
	logic                     we;
	logic [AW-1:0]            waddr;
	logic [AW-1:0]            raddr;
	logic [DATA_W-1:0]        rdata;

	logic                     is_full;
	logic                     is_empty;
	logic [AW:0]              back_sum;
	logic [AW:0]              last_sum;
	logic [AW-1:0]            back_idx;
	logic [AW-1:0]            last_idx;
	logic [AW-1:0]            prev_front;
	logic [AW-1:0]            next_front;

	assign busy = 1'b0;

	assign is_full  = (occ_q == FULL_CNT);
	assign is_empty = (occ_q == '0);

	assign back_sum = {1'b0, front_q} + (AW+1)'(occ_q);
	assign last_sum = back_sum - (AW+1)'(1);
	assign back_idx = (back_sum >= WRAP_SPAN) ? AW'(back_sum - WRAP_SPAN) : back_sum[AW-1:0];
	assign last_idx = (last_sum >= WRAP_SPAN) ? AW'(last_sum - WRAP_SPAN) : last_sum[AW-1:0];
	assign prev_front = (front_q == '0) ? LAST_IDX : front_q - AW'(1);
	assign next_front = (front_q == LAST_IDX) ? '0 : front_q + AW'(1);

	always_comb begin
		front_d  = front_q;
		occ_d    = occ_q;
		rev_d    = rev_q;
		status_d = STATUS_OK;
		pop_ok_d = 1'b0;
		we       = 1'b0;
		waddr    = back_idx;
		raddr    = front_q;
		unique case (kind_s1)
			KIND_PUSH_TAIL, KIND_PUSH_HEAD: begin
				if (is_full) begin
					status_d = STATUS_FULL;
				end else begin
					we    = valid_s1;
					occ_d = occ_q + CW'(1);
					if ((kind_s1 == KIND_PUSH_TAIL) == !rev_q) begin
						waddr = back_idx;
					end else begin
						waddr   = prev_front;
						front_d = prev_front;
					end
				end
			end
			KIND_POP_HEAD, KIND_POP_TAIL: begin
				if (is_empty) begin
					status_d = STATUS_EMPTY;
				end else begin
					pop_ok_d = 1'b1;
					occ_d    = occ_q - CW'(1);
					if ((kind_s1 == KIND_POP_HEAD) == !rev_q) begin
						raddr   = front_q;
						front_d = next_front;
					end else begin
						raddr = last_idx;
					end
				end
			end
			KIND_REVERSE: begin
				rev_d = !rev_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			front_q  <= '0;
			occ_q    <= '0;
			rev_q    <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				front_q <= front_d;
				occ_q   <= occ_d;
				rev_q   <= rev_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			kind_s1  <= kind;
			value_s1 <= value;
		end
		status_s2 <= status_d;
		count_s2  <= occ_d;
		pop_ok_s2 <= pop_ok_d;
	end

	rdq_ram #(
		.WIDTH (DATA_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (value_s1),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign done   = valid_s2;
	assign status = status_s2;
	assign count  = count_s2;
	assign popped = pop_ok_s2 ? $signed(rdata)
		: ((status_s2 == STATUS_EMPTY) ? POP_EMPTY_VALUE : '0);

endmodule

/* rtl/rdq_chk.sv */
// Port-level checker for the reversible deque, bound to the top level.
module rdq_chk
	import rdq_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       start,
	input logic                       busy,
	input logic                       done,
	input logic signed [DATA_W-1:0]   popped,
	input logic [STATUS_W-1:0]        status,
	input logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int CW = $clog2(DEPTH + 1);

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##2 done)
		else $error("transaction accepted without a result two cycles later");

	a_empty_pop: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == STATUS_EMPTY |-> popped == POP_EMPTY_VALUE && count == '0)
		else $error("empty pop must return -1 with count zero");

	a_full_push: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == STATUS_FULL |-> count == CW'(DEPTH) && popped == '0)
		else $error("rejected push must report a full queue");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> count <= CW'(DEPTH) && status <= STATUS_W'(STATUS_FULL))
		else $error("count or status out of range");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		done && $past(done) |-> (CW+1)'(count) <= (CW+1)'($past(count)) + (CW+1)'(1)
			&& (CW+1)'($past(count)) <= (CW+1)'(count) + (CW+1)'(1))
		else $error("count moved by more than one between back-to-back results");

endmodule

bind reversible_deque_top rdq_chk #(
	.DEPTH (DEPTH)
) u_rdq_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.popped (popped),
	.status (status),
	.count  (count)
);
